FILE: rtl/core/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg: shared definitions for the latency histogram unit
// Sizes, codes, tier widths and percentile ratios used by the histogram core
// and its serial divider.
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam int TIERS   = 4;
  localparam int BUCKETS = 100;
  localparam int LARGEST = 8;

  localparam int ENTRIES = TIERS * BUCKETS;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int WI_W    = $clog2(ENTRIES + 2);
  localparam int CNT_W   = 32;
  localparam int SUM_W   = CNT_W + $clog2(ENTRIES);
  localparam int QUO_W   = 7;
  localparam int DVD_W   = SUM_W + QUO_W;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int ITEMS   = 5 + LARGEST;
  localparam int ITEM_W  = $clog2(ITEMS);
  localparam int LIDX_W  = (LARGEST > 1) ? $clog2(LARGEST) : 1;
  localparam int TIER_W  = 2;
  localparam int BKT_W   = 7;
  localparam int TIME_W  = 27;
  localparam int WIDTH_W = 20;
  localparam int RCP_W   = 28;
  localparam int PROD_W  = TIME_W + RCP_W;

  localparam logic [31:0] SAT_LIMIT = 32'd2000000000;
  localparam logic [31:0] SAT_VALUE = 32'hFFFF_FFFF;
  localparam logic [QUO_W-1:0] SHARE_MAX = 7'd100;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_PCT     = 2'd1;
  localparam logic [1:0] KIND_LARGEST = 2'd2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 272;

  // Bucket width of a tier in ns.
  function automatic logic [WIDTH_W-1:0] tier_width(input logic [TIER_W-1:0] d);
    logic [WIDTH_W-1:0] w;
    case (d)
      2'd0:    w = 20'd1000;
      2'd1:    w = 20'd10000;
      2'd2:    w = 20'd100000;
      default: w = 20'd1000000;
    endcase
    return w;
  endfunction

  // Rounded-up reciprocal of a tier width, scaled by 2^27, 2^34, 2^40 and
  // 2^47 per tier; exact for every sample below the tier's limit.
  function automatic logic [RCP_W-1:0] tier_recip(input logic [TIER_W-1:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      2'd0:    r = 28'd134218;
      2'd1:    r = 28'd1717987;
      2'd2:    r = 28'd10995117;
      default: r = 28'd140737489;
    endcase
    return r;
  endfunction

  // Exclusive upper bound of the samples a tier covers.
  function automatic logic [TIME_W-1:0] tier_limit(input logic [TIER_W-1:0] d);
    logic [TIME_W-1:0] l;
    case (d)
      2'd0:    l = 27'd100000;
      2'd1:    l = 27'd1000000;
      2'd2:    l = 27'd10000000;
      default: l = 27'd100000000;
    endcase
    return l;
  endfunction

  // Percentile p is reached when sum * den >= count * num.
  function automatic logic [QUO_W-1:0] pct_num(input logic [1:0] p);
    logic [QUO_W-1:0] n;
    case (p)
      2'd0:    n = 7'd1;
      2'd1:    n = 7'd9;
      2'd2:    n = 7'd95;
      default: n = 7'd99;
    endcase
    return n;
  endfunction

  function automatic logic [QUO_W-1:0] pct_den(input logic [1:0] p);
    logic [QUO_W-1:0] n;
    case (p)
      2'd0:    n = 7'd2;
      2'd1:    n = 7'd10;
      default: n = 7'd100;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/lhp_div.sv
// ----------------------------------------------------------------------------
// lhp_div: serial restoring divider with a short quotient
// Produces a seven-bit quotient one bit per cycle and flags a quotient that
// does not fit.
// ----------------------------------------------------------------------------
module lhp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lhp_pkg::DVD_W-1:0] dividend_i,
  input  logic [31:0]               divisor_i,
  output logic                      done_o,
  output logic [lhp_pkg::QUO_W-1:0] quot_o,
  output logic                      ovf_o
);

  logic [lhp_pkg::DVD_W-1:0]  rem_q;
  logic [31:0]                dsr_q;
  logic [lhp_pkg::QUO_W-1:0]  quot_q;
  logic                       ovf_q;
  logic [lhp_pkg::STEP_W-1:0] step_q;
  logic                       busy_q;
  logic                       done_q;
  logic [lhp_pkg::DVD_W-1:0]  trial;

  assign trial = lhp_pkg::DVD_W'(dsr_q) << step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= lhp_pkg::STEP_W'(lhp_pkg::QUO_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= divisor_i;
      quot_q <= '0;
      ovf_q  <= dividend_i >= (lhp_pkg::DVD_W'(divisor_i) << lhp_pkg::QUO_W);
    end else if (busy_q && rem_q >= trial) begin
      rem_q          <= rem_q - trial;
      quot_q[step_q] <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

FILE: rtl/core/latency_histogram_percentiles_unit.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentiles_unit: latency statistics with percentiles
// A record updates the statistics on acceptance; a sample that enters the
// histogram then passes S_RDIV (a reciprocal multiply with the bucket read)
// and S_RRD (its write back). A report walks all 400 buckets, runs 8 share
// divisions and then hands out 13 results, one per cycle while the sink is ready.
// After reset, and after every clear, a pass zeroes the bucket memory while
// no request is taken.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata from bit 0: duration_ns[31:0], clear_after[32], zero padding.
  input  logic [lhp_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: mode[1:0].
  input  logic [1:0]                     s_axis_tuser_i,
  // Result channel.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata from bit 0: entry_index[4:0], event_count[36:5], total_time[100:37],
  // min_time[132:101], max_time[164:133], nominal_time[191:165],
  // nominal_share[198:192], floor_time[225:199], floor_share[232:226],
  // largest_time[264:233], zero padding.
  output logic [lhp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: kind[1:0].
  output logic [1:0]                     m_axis_tuser_o,
  // tlast: last.
  output logic                           m_axis_tlast_o
);

  // The control sequencer is one-hot.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDIV  = 7'b0000100,
    S_RRD   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q;

  // Scalar statistics and the descending list of the largest samples.
  logic [lhp_pkg::CNT_W-1:0] cnt_q;
  logic [63:0]               sum_q;
  logic [31:0]               min_q;
  logic [31:0]               max_q;
  logic [31:0]               top_q [lhp_pkg::LARGEST];
  logic [31:0]               top_new [lhp_pkg::LARGEST];

  // Bucket memory with one write port and one registered read port.
  logic [31:0]                mem [lhp_pkg::ENTRIES];
  logic [31:0]                rdata_q;
  logic                       mem_we;
  logic [lhp_pkg::ADDR_W-1:0] mem_waddr;
  logic [31:0]                mem_wdata;
  logic [lhp_pkg::ADDR_W-1:0] mem_raddr;
  logic [lhp_pkg::ADDR_W-1:0] clr_addr_q;
  logic [lhp_pkg::ADDR_W-1:0] baddr_q;

  // Record path.
  logic                        s_acc;
  logic [31:0]                 dur;
  logic [31:0]                 t_sat;
  logic [lhp_pkg::TIER_W-1:0]  t_tier;
  logic                        t_hist;
  logic [lhp_pkg::TIER_W-1:0]  tier_q;
  logic [lhp_pkg::TIME_W-1:0]  t_q;
  logic [lhp_pkg::PROD_W-1:0]  prod;
  logic [lhp_pkg::BKT_W-1:0]   rquot;
  logic [lhp_pkg::BKT_W-1:0]   bucket;
  logic [lhp_pkg::ADDR_W-1:0]  bucket_addr;

  // Shared divider.
  logic                        div_start;
  logic [lhp_pkg::DVD_W-1:0]   div_dvd;
  logic [31:0]                 div_dsr;
  logic                        div_done;
  logic [lhp_pkg::QUO_W-1:0]   div_quot;
  logic                        div_ovf;
  logic                        dbusy_q;
  logic [2:0]                  dv_q;
  logic [lhp_pkg::SUM_W-1:0]   dv_part;
  logic [lhp_pkg::QUO_W-1:0]   dv_share;

  // Histogram walk: issue counters, data stage and threshold stage.
  logic [lhp_pkg::WI_W-1:0]    wi_q;
  logic [lhp_pkg::TIER_W-1:0]  wt_q, p1t_q, p2t_q;
  logic [lhp_pkg::BKT_W-1:0]   wj_q, p1j_q, p2j_q;
  logic                        p1v_q, p2v_q;
  logic [31:0]                 p2cur_q;
  logic [lhp_pkg::SUM_W-1:0]   sumw_q;
  logic                        clr_after_q;

  // Per-percentile results.
  logic                        found_q [4];
  logic [lhp_pkg::TIME_W-1:0]  nom_q [4];
  logic [lhp_pkg::TIME_W-1:0]  flr_q [4];
  logic [lhp_pkg::SUM_W-1:0]   npart_q [4];
  logic [lhp_pkg::SUM_W-1:0]   fpart_q [4];
  logic [lhp_pkg::QUO_W-1:0]   nsh_q [4];
  logic [lhp_pkg::QUO_W-1:0]   fsh_q [4];
  logic [lhp_pkg::TIME_W-1:0]  p2_nom;
  logic [lhp_pkg::TIME_W-1:0]  p2_w;

  // Result register.
  logic [lhp_pkg::ITEM_W-1:0]     ecnt_q;
  logic                           mv_q;
  logic [lhp_pkg::OUT_DATA_W-1:0] mdata_q;
  logic [1:0]                     mkind_q;
  logic                           mlast_q;
  logic                           m_load;
  logic [lhp_pkg::OUT_DATA_W-1:0] it_data;
  logic [1:0]                     it_kind;
  logic [1:0]                     it_p;
  logic [lhp_pkg::LIDX_W-1:0]     it_k;
  logic [4:0]                     it_idx;
  logic [lhp_pkg::CNT_W-1:0]      it_cnt;
  logic [63:0]                    it_sum;
  logic [31:0]                    it_min, it_max, it_large;
  logic [lhp_pkg::TIME_W-1:0]     it_nom, it_flr;
  logic [lhp_pkg::QUO_W-1:0]      it_nsh, it_fsh;

  logic do_clear;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign dur             = s_axis_tdata_i[31:0];

  // Saturate the sample and pick the first tier whose range holds it.
  always_comb begin
    t_sat  = (dur > lhp_pkg::SAT_LIMIT) ? lhp_pkg::SAT_VALUE : dur;
    t_tier = lhp_pkg::TIER_W'(lhp_pkg::TIERS - 1);
    for (int d = lhp_pkg::TIERS - 1; d >= 0; d--) begin
      if (t_sat < 32'(lhp_pkg::tier_limit(lhp_pkg::TIER_W'(d)))) begin
        t_tier = lhp_pkg::TIER_W'(d);
      end
    end
    t_hist = t_sat < 32'(lhp_pkg::tier_limit(lhp_pkg::TIER_W'(lhp_pkg::TIERS - 1)));
  end

  // The new sample goes in front of the first entry it exceeds.
  always_comb begin
    for (int i = 0; i < lhp_pkg::LARGEST; i++) begin
      if (!(t_sat > top_q[i])) begin
        top_new[i] = top_q[i];
      end else if (i == 0) begin
        top_new[i] = t_sat;
      end else if (!(t_sat > top_q[(i > 0) ? i - 1 : 0])) begin
        top_new[i] = t_sat;
      end else begin
        top_new[i] = top_q[(i > 0) ? i - 1 : 0];
      end
    end
  end

  // Multiplying by the scaled reciprocal of the tier width gives the exact
  // quotient for every sample the tier covers.
  always_comb begin
    prod = lhp_pkg::PROD_W'(t_q) * lhp_pkg::PROD_W'(lhp_pkg::tier_recip(tier_q));
    case (tier_q)
      2'd0:    rquot = prod[33:27];
      2'd1:    rquot = prod[40:34];
      2'd2:    rquot = prod[46:40];
      default: rquot = prod[53:47];
    endcase
  end

  // A quotient of zero means the sample is below its tier's width.
  assign bucket      = (rquot == '0) ? lhp_pkg::BKT_W'(1) : rquot;
  assign bucket_addr = lhp_pkg::ADDR_W'(tier_q) * lhp_pkg::ADDR_W'(lhp_pkg::BUCKETS)
                     + lhp_pkg::ADDR_W'(bucket);

  // Divider operands: percent shares on reports.
  always_comb begin
    dv_part   = dv_q[0] ? fpart_q[dv_q[2:1]] : npart_q[dv_q[2:1]];
    div_dvd   = lhp_pkg::DVD_W'(dv_part) * lhp_pkg::DVD_W'(7'd100);
    div_dsr   = cnt_q;
    div_start = (state_q == S_DIV) && !dbusy_q;
  end

  always_comb begin
    if (cnt_q == '0) begin
      dv_share = '0;
    end else if (div_ovf || div_quot > lhp_pkg::SHARE_MAX) begin
      dv_share = lhp_pkg::SHARE_MAX;
    end else begin
      dv_share = div_quot;
    end
  end

  lhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .ovf_o      (div_ovf)
  );

  // Memory port control: the clearing pass and the bucket increment write,
  // the record path and the walk read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = baddr_q;
    mem_wdata = (rdata_q == lhp_pkg::SAT_VALUE) ? rdata_q : rdata_q + 32'd1;
    mem_raddr = bucket_addr;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      S_RRD: begin
        mem_we = 1'b1;
      end
      S_WALK: begin
        mem_raddr = wi_q[lhp_pkg::ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Bucket position times its tier width at the threshold stage.
  assign p2_w   = lhp_pkg::TIME_W'(lhp_pkg::tier_width(p2t_q));
  assign p2_nom = lhp_pkg::TIME_W'(p2j_q) * p2_w;

  // Build the result item selected by the emission counter.
  always_comb begin
    it_kind  = lhp_pkg::KIND_SUMMARY;
    it_idx   = '0;
    it_cnt   = '0;
    it_sum   = '0;
    it_min   = '0;
    it_max   = '0;
    it_nom   = '0;
    it_nsh   = '0;
    it_flr   = '0;
    it_fsh   = '0;
    it_large = '0;
    it_p     = 2'(ecnt_q - lhp_pkg::ITEM_W'(1));
    it_k     = lhp_pkg::LIDX_W'(ecnt_q - lhp_pkg::ITEM_W'(5));
    if (ecnt_q == '0) begin
      it_cnt = cnt_q;
      it_sum = sum_q;
      it_min = min_q;
      it_max = max_q;
    end else if (ecnt_q < lhp_pkg::ITEM_W'(5)) begin
      it_kind = lhp_pkg::KIND_PCT;
      it_idx  = 5'(it_p);
      if (found_q[it_p]) begin
        it_nom = nom_q[it_p];
        it_nsh = nsh_q[it_p];
        it_flr = flr_q[it_p];
        it_fsh = fsh_q[it_p];
      end
    end else begin
      it_kind  = lhp_pkg::KIND_LARGEST;
      it_idx   = 5'(it_k);
      it_large = top_q[it_k];
    end
    it_data = {7'd0, it_large, it_fsh, it_flr, it_nsh, it_nom,
               it_max, it_min, it_sum, it_cnt, it_idx};
  end

  assign m_load = (state_q == S_EMIT) && (!mv_q || m_axis_tready_i);

  // Clear on a clear request and after a report that asks for it.
  assign do_clear = (s_acc && s_axis_tuser_i == lhp_pkg::MODE_CLEAR)
                 || (m_load && ecnt_q == lhp_pkg::ITEM_W'(lhp_pkg::ITEMS - 1)
                     && clr_after_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      for (int i = 0; i < lhp_pkg::LARGEST; i++) top_q[i] <= '0;
      mv_q        <= 1'b0;
      ecnt_q      <= '0;
      dbusy_q     <= 1'b0;
      dv_q        <= '0;
      wi_q        <= '0;
      p1v_q       <= 1'b0;
      p2v_q       <= 1'b0;
      clr_after_q <= 1'b0;
      for (int p = 0; p < 4; p++) found_q[p] <= 1'b0;
    end else begin
      if (mv_q && m_axis_tready_i && !m_load) begin
        mv_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_addr_q == lhp_pkg::ADDR_W'(lhp_pkg::ENTRIES - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            case (s_axis_tuser_i)
              lhp_pkg::MODE_RECORD: begin
                if (cnt_q != lhp_pkg::SAT_VALUE) cnt_q <= cnt_q + 1'b1;
                sum_q <= sum_q + 64'(t_sat);
                if (min_q == '0 || t_sat < min_q) min_q <= t_sat;
                if (t_sat > max_q) max_q <= t_sat;
                for (int i = 0; i < lhp_pkg::LARGEST; i++) top_q[i] <= top_new[i];
                if (t_hist) begin
                  t_q     <= lhp_pkg::TIME_W'(t_sat);
                  tier_q  <= t_tier;
                  state_q <= S_RDIV;
                end
              end
              lhp_pkg::MODE_REPORT: begin
                clr_after_q <= s_axis_tdata_i[32];
                sumw_q      <= '0;
                wi_q        <= '0;
                wt_q        <= '0;
                wj_q        <= '0;
                p1v_q       <= 1'b0;
                p2v_q       <= 1'b0;
                for (int p = 0; p < 4; p++) found_q[p] <= 1'b0;
                state_q     <= S_WALK;
              end
              lhp_pkg::MODE_CLEAR: begin
                state_q <= S_CLEAR;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RDIV: begin
          // The bucket read is issued at this edge from the product.
          baddr_q <= bucket_addr;
          state_q <= S_RRD;
        end
        S_RRD: begin
          state_q <= S_IDLE;
        end
        S_WALK: begin
          // Issue one bucket read per cycle and track its tier and position.
          p1v_q <= wi_q < lhp_pkg::WI_W'(lhp_pkg::ENTRIES);
          p1t_q <= wt_q;
          p1j_q <= wj_q;
          if (wj_q == lhp_pkg::BKT_W'(lhp_pkg::BUCKETS - 1)) begin
            wj_q <= '0;
            wt_q <= wt_q + 1'b1;
          end else begin
            wj_q <= wj_q + 1'b1;
          end
          // Accumulate non-empty buckets until the running sum reaches count.
          if (p1v_q && sumw_q < lhp_pkg::SUM_W'(cnt_q) && rdata_q != '0) begin
            sumw_q  <= sumw_q + lhp_pkg::SUM_W'(rdata_q);
            p2v_q   <= 1'b1;
            p2cur_q <= rdata_q;
            p2t_q   <= p1t_q;
            p2j_q   <= p1j_q;
          end else begin
            p2v_q <= 1'b0;
          end
          // Capture each percentile at the first bucket that reaches it.
          if (p2v_q) begin
            for (int p = 0; p < 4; p++) begin
              if (!found_q[p]
                  && lhp_pkg::DVD_W'(sumw_q) * lhp_pkg::DVD_W'(lhp_pkg::pct_den(2'(p)))
                     >= lhp_pkg::DVD_W'(cnt_q) * lhp_pkg::DVD_W'(lhp_pkg::pct_num(2'(p)))) begin
                found_q[p] <= 1'b1;
                nom_q[p]   <= p2_nom;
                flr_q[p]   <= p2_nom - p2_w;
                npart_q[p] <= sumw_q;
                fpart_q[p] <= sumw_q - lhp_pkg::SUM_W'(p2cur_q);
              end
            end
          end
          if (wi_q == lhp_pkg::WI_W'(lhp_pkg::ENTRIES + 1)) begin
            dv_q    <= '0;
            dbusy_q <= 1'b0;
            state_q <= S_DIV;
          end else begin
            wi_q <= wi_q + 1'b1;
          end
        end
        S_DIV: begin
          if (!dbusy_q) begin
            dbusy_q <= 1'b1;
          end else if (div_done) begin
            dbusy_q <= 1'b0;
            if (dv_q[0]) begin
              fsh_q[dv_q[2:1]] <= dv_share;
            end else begin
              nsh_q[dv_q[2:1]] <= dv_share;
            end
            dv_q <= dv_q + 1'b1;
            if (dv_q == 3'd7) begin
              ecnt_q  <= '0;
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (m_load) begin
            mv_q   <= 1'b1;
            ecnt_q <= ecnt_q + 1'b1;
            if (ecnt_q == lhp_pkg::ITEM_W'(lhp_pkg::ITEMS - 1)) begin
              state_q <= clr_after_q ? S_CLEAR : S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // A clear empties the statistics at once and zeroes the memory by a pass.
      if (do_clear) begin
        cnt_q      <= '0;
        sum_q      <= '0;
        min_q      <= '0;
        max_q      <= '0;
        for (int i = 0; i < lhp_pkg::LARGEST; i++) top_q[i] <= '0;
        clr_addr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      mdata_q <= it_data;
      mkind_q <= it_kind;
      mlast_q <= (ecnt_q == lhp_pkg::ITEM_W'(lhp_pkg::ITEMS - 1));
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = mkind_q;
  assign m_axis_tlast_o  = mlast_q;

endmodule

FILE: sim/latency_histogram_percentiles_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latency_histogram_percentiles_unit_test: self-checking bench for the unit
// Drives records, reports and clears over the request stream, predicts every
// report item with a behavioral model of the statistics, and compares each
// returned item field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles_unit_test;

  localparam int STALL_LIMIT = 20000;

  // One returned report item, in output field order.
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  entry_index;
    logic [31:0] event_count;
    logic [63:0] total_time;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [26:0] nominal_time;
    logic [6:0]  nominal_share;
    logic [26:0] floor_time;
    logic [6:0]  floor_share;
    logic [31:0] largest_time;
    logic        last;
  } report_item_t;

  // One request of the directed table. chk marks rows before which the model's
  // count, minimum and maximum are compared with typed-in values.
  typedef struct {
    logic [1:0]  mode;
    logic [31:0] dur;
    logic        clr;
    logic        chk;
    logic [31:0] cnt;
    logic [31:0] mn;
    logic [31:0] mx;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [lhp_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [lhp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  always #1 clk_i = ~clk_i;

  latency_histogram_percentiles_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Predicted statistics of the unit.
  logic [31:0] pr_count;
  logic [63:0] pr_sum;
  logic [31:0] pr_min;
  logic [31:0] pr_max;
  logic [31:0] pr_top [lhp_pkg::LARGEST];
  logic [31:0] pr_bkt [lhp_pkg::ENTRIES];

  report_item_t expected_items[$];
  int errors = 0;
  int idle_cycles = 0;
  int m_hold = 0;

  task automatic report_error(input string what);
    errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic void clear_stats();
    pr_count = '0;
    pr_sum = '0;
    pr_min = '0;
    pr_max = '0;
    foreach (pr_top[i]) pr_top[i] = '0;
    foreach (pr_bkt[i]) pr_bkt[i] = '0;
  endfunction

  function automatic void add_sample(input logic [31:0] raw);
    logic [31:0] t;
    logic [31:0] w;
    logic [31:0] b;
    int d;
    t = (raw > lhp_pkg::SAT_LIMIT) ? lhp_pkg::SAT_VALUE : raw;
    if (pr_count != 32'hFFFF_FFFF) pr_count++;
    pr_sum += {32'd0, t};
    if (pr_min == 0 || t < pr_min) pr_min = t;
    if (t > pr_max) pr_max = t;
    // Saturated samples never enter the histogram; 100 ms and up neither.
    if (t != lhp_pkg::SAT_VALUE) begin
      w = 32'd1000;
      for (d = 0; d < lhp_pkg::TIERS; d++) begin
        if ({32'd0, t} < {32'd0, w} * 64'd100) begin
          b = (t < w) ? 32'd1 : t / w;
          if (b < lhp_pkg::BUCKETS && pr_bkt[d*lhp_pkg::BUCKETS + b] != 32'hFFFF_FFFF)
            pr_bkt[d*lhp_pkg::BUCKETS + b]++;
          break;
        end
        w = w * 10;
      end
    end
    // Descending list of the largest samples: insert and shift down.
    for (int i = 0; i < lhp_pkg::LARGEST; i++) begin
      if (t > pr_top[i]) begin
        for (int j = lhp_pkg::LARGEST - 1; j > i; j--) pr_top[j] = pr_top[j-1];
        pr_top[i] = t;
        break;
      end
    end
  endfunction

  function automatic logic [6:0] percent_of(input logic [63:0] part, input logic [63:0] whole);
    logic [63:0] s;
    if (whole == 0) return '0;
    s = (part * 100) / whole;
    return (s > 100) ? 7'd100 : s[6:0];
  endfunction

  // Builds the items of one report: summary, four percentiles, largest list.
  function automatic void predict_report();
    report_item_t it;
    report_item_t pct [4];
    logic [63:0] num [4];
    logic [63:0] den [4];
    bit found [4];
    logic [63:0] cnt;
    logic [63:0] acc;
    logic [63:0] cur;
    logic [63:0] w;
    logic [63:0] nom;
    num = '{1, 9, 95, 99};
    den = '{2, 10, 100, 100};
    cnt = {32'd0, pr_count};
    acc = '0;
    w = 64'd1000;
    it = '0;
    it.kind = lhp_pkg::KIND_SUMMARY;
    it.event_count = pr_count;
    it.total_time = pr_sum;
    it.min_time = pr_min;
    it.max_time = pr_max;
    expected_items.push_back(it);
    for (int p = 0; p < 4; p++) begin
      pct[p] = '0;
      pct[p].kind = lhp_pkg::KIND_PCT;
      pct[p].entry_index = 5'(p);
      found[p] = 1'b0;
    end
    for (int d = 0; d < lhp_pkg::TIERS; d++) begin
      for (int j = 0; j < lhp_pkg::BUCKETS && acc < cnt; j++) begin
        cur = {32'd0, pr_bkt[d*lhp_pkg::BUCKETS + j]};
        if (cur == 0) continue;
        acc += cur;
        for (int p = 0; p < 4; p++) begin
          if (!found[p] && acc * den[p] >= cnt * num[p]) begin
            found[p] = 1'b1;
            nom = 64'(j) * w;
            pct[p].nominal_time = nom[26:0];
            pct[p].nominal_share = percent_of(acc, cnt);
            pct[p].floor_time = 27'((nom - w) & 64'h7FF_FFFF);
            pct[p].floor_share = percent_of(acc - cur, cnt);
          end
        end
      end
      w = w * 10;
    end
    for (int p = 0; p < 4; p++) expected_items.push_back(pct[p]);
    for (int k = 0; k < lhp_pkg::LARGEST; k++) begin
      it = '0;
      it.kind = lhp_pkg::KIND_LARGEST;
      it.entry_index = 5'(k);
      it.largest_time = pr_top[k];
      it.last = (k == lhp_pkg::LARGEST - 1);
      expected_items.push_back(it);
    end
  endfunction

  function automatic void apply_request(input logic [1:0] mode, input logic [31:0] dur,
                                        input logic clr);
    case (mode)
      lhp_pkg::MODE_RECORD: add_sample(dur);
      lhp_pkg::MODE_REPORT: begin
        predict_report();
        if (clr) clear_stats();
      end
      lhp_pkg::MODE_CLEAR: clear_stats();
      default: ;
    endcase
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sends one request and waits for its acceptance. Valid stays high after
  // acceptance so that a request without a gap follows at once.
  task automatic send_request(input logic [1:0] mode, input logic [31:0] dur,
                              input logic clr);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {7'd0, clr, dur};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    apply_request(mode, dur, clr);
  endtask

  // Stops sending and waits until every expected item has come back.
  task automatic hold_off();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_items.size() != 0) @(posedge clk_i);
  endtask

  // Random sample across all tiers, the saturation region and the edges.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 999);
      1, 2: return $urandom_range(1000, 99999);
      3: return $urandom_range(100000, 999999);
      4: return $urandom_range(1000000, 9999999);
      5: return $urandom_range(10000000, 99999999);
      6: return $urandom_range(100000000, 2000000000);
      7: return $urandom();
      8: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 3) * 1000;
    endcase
  endfunction

  // Result side: random stalls and the comparison.
  always @(posedge clk_i) begin
    report_item_t got;
    report_item_t exp_item;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.entry_index = m_tdata[4:0];
        got.event_count = m_tdata[36:5];
        got.total_time = m_tdata[100:37];
        got.min_time = m_tdata[132:101];
        got.max_time = m_tdata[164:133];
        got.nominal_time = m_tdata[191:165];
        got.nominal_share = m_tdata[198:192];
        got.floor_time = m_tdata[225:199];
        got.floor_share = m_tdata[232:226];
        got.largest_time = m_tdata[264:233];
        got.last = m_tlast;
        if (expected_items.size() == 0) begin
          report_error($sformatf("unexpected result %p", got));
        end else begin
          exp_item = expected_items.pop_front();
          if (got.kind != exp_item.kind) report_error("kind mismatch");
          if (got.entry_index != exp_item.entry_index) report_error("entry_index mismatch");
          if (got.event_count != exp_item.event_count) report_error("event_count mismatch");
          if (got.total_time != exp_item.total_time) report_error("total_time mismatch");
          if (got.min_time != exp_item.min_time) report_error("min_time mismatch");
          if (got.max_time != exp_item.max_time) report_error("max_time mismatch");
          if (got.nominal_time != exp_item.nominal_time) report_error("nominal_time mismatch");
          if (got.nominal_share != exp_item.nominal_share)
            report_error("nominal_share mismatch");
          if (got.floor_time != exp_item.floor_time) report_error("floor_time mismatch");
          if (got.floor_share != exp_item.floor_share) report_error("floor_share mismatch");
          if (got.largest_time != exp_item.largest_time) report_error("largest_time mismatch");
          if (got.last != exp_item.last) report_error("last mismatch");
        end
      end
      // Mostly short stalls, now and then a long one.
      if (m_hold > 0) begin
        m_tready <= 1'b0;
        m_hold <= m_hold - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        m_tready <= 1'b0;
        m_hold <= $urandom_range(10, 60);
      end else begin
        m_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Watchdog: counts cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  table_row_t dir_rows[$];
  int n_rand;

  initial begin
    logic [1:0] md;
    int r;
    clear_stats();
    // Directed table. Typed-in rows check the summary against known values.
    dir_rows = '{
      '{lhp_pkg::MODE_REPORT, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0},
      '{lhp_pkg::MODE_RECORD, 32'd0, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd999, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd1000, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd99999, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd100000, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd9999999, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd99999999, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd100000000, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd2000000000, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd2000000001, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 0},
      '{2'd3, 32'h5555_AAAA, 1'b1, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_REPORT, 32'd0, 1'b1, 1'b1, 32'd11, 32'd999, 32'hFFFF_FFFF},
      '{lhp_pkg::MODE_REPORT, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0},
      '{lhp_pkg::MODE_RECORD, 32'd2000000001, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_REPORT, 32'd0, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd5000, 1'b1, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_RECORD, 32'd5500, 1'b0, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_CLEAR, 32'h1234_5678, 1'b1, 1'b0, 0, 0, 0},
      '{lhp_pkg::MODE_REPORT, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk) begin
        if (pr_count != dir_rows[i].cnt || pr_min != dir_rows[i].mn
            || pr_max != dir_rows[i].mx)
          report_error($sformatf("directed row %0d: summary not as typed", i));
      end
      send_request(dir_rows[i].mode, dir_rows[i].dur, dir_rows[i].clr);
    end
    // Hold off until every report item has come back.
    hold_off();
    // Random part: runs of records with a report now and then.
    n_rand = 0;
    while (n_rand < 350) begin
      r = $urandom_range(0, 99);
      if (r < 82) md = lhp_pkg::MODE_RECORD;
      else if (r < 94) md = lhp_pkg::MODE_REPORT;
      else if (r < 97) md = lhp_pkg::MODE_CLEAR;
      else md = 2'd3;
      send_request(md, rand_sample(), 1'($urandom_range(0, 1)));
      if (md != 2'd3) n_rand++;
      if (n_rand == 175) hold_off();
    end
    send_request(lhp_pkg::MODE_REPORT, $urandom(), 1'b0);
    hold_off();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lhp_pkg.sv
rtl/core/lhp_div.sv
rtl/core/latency_histogram_percentiles_unit.sv
sim/latency_histogram_percentiles_unit_test.sv
